// ===== hw/rtl/hrd_pkg.sv =====
package hrd_pkg;

  localparam int AVG_WINDOW_DEF = 5;

  localparam int SAMPLE_W   = 18;
  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 16;
  localparam int RATE_W     = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [SAMPLE_W-1:0]   NO_SIGNAL_RST = 18'd30000;
  localparam logic [SAMPLE_W-1:0]   BEAT_RST      = 18'd50000;
  localparam logic [INTERVAL_W-1:0] MIN_IVL_RST   = 16'd400;
  localparam logic [INTERVAL_W-1:0] MAX_IVL_RST   = 16'd2000;
  localparam logic [RATE_W-1:0]     RATE_NUM      = 16'd60000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NO_SIGNAL = 2'd0,
    REG_BEAT      = 2'd1,
    REG_MIN_IVL   = 2'd2,
    REG_MAX_IVL   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SUM,
    S_DIV1,
    S_DIV2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } ring_ctl_t;

endpackage

// ===== hw/rtl/hrd_divider.sv =====
module hrd_divider import hrd_pkg::*; #(
  parameter int DVD_W = 21,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!diff[DVS_W]) begin
        rem_nxt = diff[DVS_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ===== hw/rtl/hrd_ring.sv =====
module hrd_ring import hrd_pkg::*; #(
  parameter int AVG_WINDOW = AVG_WINDOW_DEF,
  parameter int FILL_W     = $clog2(AVG_WINDOW + 1),
  parameter int SUM_W      = INTERVAL_W + FILL_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ring_ctl_t             ctl,
  input  logic [INTERVAL_W-1:0] wr_data,
  output logic                  done,
  output logic [SUM_W-1:0]      sum,
  output logic [FILL_W-1:0]     fill
);

  localparam int IDX_W = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;

  logic [INTERVAL_W-1:0] mem [AVG_WINDOW];
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [SUM_W-1:0]      acc_r, acc_nxt;
  logic [SUM_W-1:0]      acc_add;
  logic [INTERVAL_W-1:0] rd_r;

  assign acc_add = acc_r + SUM_W'(rd_r);

  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    if (ctl.clr) begin
      pos_nxt  = '0;
      fill_nxt = '0;
      busy_nxt = 1'b0;
    end else if (ctl.wr) begin
      pos_nxt  = (pos_r == IDX_W'(AVG_WINDOW - 1)) ? '0 : pos_r + IDX_W'(1);
      fill_nxt = (fill_r == FILL_W'(AVG_WINDOW)) ? fill_r : fill_r + FILL_W'(1);
      idx_nxt  = '0;
      acc_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_add;
      if (FILL_W'(idx_r) + FILL_W'(1) == fill_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
    if (ctl.wr && !ctl.clr) begin
      mem[pos_r] <= wr_data;
    end
    if (ctl.wr && !ctl.clr && pos_r == idx_nxt) begin
      rd_r <= wr_data;
    end else begin
      rd_r <= mem[idx_nxt];
    end
  end

  assign done = done_r;
  assign sum  = acc_r;
  assign fill = fill_r;

endmodule

// ===== hw/rtl/ppg_heart_rate_detector.sv =====
// Path: an accepted input passes S_EVAL and S_OUT to the registered result without a new beat
// interval; with one, also S_SUM, S_DIV1 and S_DIV2, of which a zero mean skips S_DIV2.
// Throughput: one item at a time; in_tready is high only in S_IDLE, and S_OUT waits on out_tready.
// Bit-serial divider, one quotient bit per cycle, and one-entry-per-cycle interval sum dominate.
// Reset: synchronous, active low; restores register defaults, clears history and rate.
module ppg_heart_rate_detector import hrd_pkg::*; #(
  parameter int AVG_WINDOW = AVG_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [55:0]           in_tdata,   // ir_sample[17:0], time_ms[49:18], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // rate_bpm[15:0], beat_accepted[16], no_signal[17]
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int FILL_W = $clog2(AVG_WINDOW + 1);
  localparam int SUM_W  = INTERVAL_W + FILL_W;

  logic [SAMPLE_W-1:0]   no_signal_level_r, beat_level_r;
  logic [INTERVAL_W-1:0] min_ivl_r, max_ivl_r;

  state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] ir_r, ir_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [SAMPLE_W:0]   pslope_r, pslope_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic                beat_r, beat_nxt;
  logic                nosig_r, nosig_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [RATE_W-1:0]   out_rate_r, out_rate_nxt;
  logic                out_beat_r, out_beat_nxt;
  logic                out_nosig_r, out_nosig_nxt;

  logic [SAMPLE_W:0]  slope;
  logic [TIME_W-1:0]  elapsed;
  logic               below, candidate, enter;

  ring_ctl_t          ring_ctl;
  logic               ring_done;
  logic [SUM_W-1:0]   ring_sum;
  logic [FILL_W-1:0]  ring_fill;

  logic               div_start;
  logic [SUM_W-1:0]   div_dividend;
  logic [INTERVAL_W-1:0] div_divisor;
  logic               div_done;
  logic [SUM_W-1:0]   div_quot;

  logic in_fire;

  assign in_fire = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_signal_level_r <= NO_SIGNAL_RST;
      beat_level_r      <= BEAT_RST;
      min_ivl_r         <= MIN_IVL_RST;
      max_ivl_r         <= MAX_IVL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_NO_SIGNAL: no_signal_level_r <= cfg_wdata;
        REG_BEAT:      beat_level_r      <= cfg_wdata;
        REG_MIN_IVL:   min_ivl_r         <= cfg_wdata[INTERVAL_W-1:0];
        REG_MAX_IVL:   max_ivl_r         <= cfg_wdata[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign slope     = {1'b0, ir_r} - {1'b0, prev_r};
  assign elapsed   = time_r - last_r;
  assign below     = ir_r < no_signal_level_r;
  assign candidate = !pslope_r[SAMPLE_W] && (pslope_r != '0) && slope[SAMPLE_W]
                     && (prev_r > beat_level_r) && (elapsed >= TIME_W'(min_ivl_r));
  assign enter     = elapsed <= TIME_W'(max_ivl_r);

  always_comb begin
    state_nxt     = state_r;
    ir_nxt        = ir_r;
    time_nxt      = time_r;
    prev_nxt      = prev_r;
    pslope_nxt    = pslope_r;
    last_nxt      = last_r;
    rate_nxt      = rate_r;
    beat_nxt      = beat_r;
    nosig_nxt     = nosig_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rate_nxt  = out_rate_r;
    out_beat_nxt  = out_beat_r;
    out_nosig_nxt = out_nosig_r;
    ring_ctl      = '0;
    div_start     = 1'b0;
    div_dividend  = ring_sum;
    div_divisor   = INTERVAL_W'(ring_fill);
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ir_nxt    = in_tdata[17:0];
          time_nxt  = in_tdata[49:18];
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        beat_nxt  = 1'b0;
        nosig_nxt = below;
        prev_nxt  = ir_r;
        state_nxt = S_OUT;
        if (below) begin
          rate_nxt     = '0;
          last_nxt     = time_r;
          pslope_nxt   = '0;
          ring_ctl.clr = 1'b1;
        end else begin
          pslope_nxt = slope;
          if (candidate) begin
            last_nxt = time_r;
            if (enter) begin
              ring_ctl.wr = 1'b1;
              beat_nxt    = 1'b1;
              state_nxt   = S_SUM;
            end
          end
        end
      end
      S_SUM: begin
        if (ring_done) begin
          div_start = 1'b1;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        div_dividend = SUM_W'(RATE_NUM);
        div_divisor  = div_quot[INTERVAL_W-1:0];
        if (div_done) begin
          if (div_quot[INTERVAL_W-1:0] == '0) begin
            rate_nxt  = '0;
            state_nxt = S_OUT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (div_done) begin
          rate_nxt  = div_quot[RATE_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_rate_nxt  = rate_r;
          out_beat_nxt  = beat_r;
          out_nosig_nxt = nosig_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      pslope_r    <= '0;
      last_r      <= '0;
      rate_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      pslope_r    <= pslope_nxt;
      last_r      <= last_nxt;
      rate_r      <= rate_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ir_r        <= ir_nxt;
    time_r      <= time_nxt;
    beat_r      <= beat_nxt;
    nosig_r     <= nosig_nxt;
    out_rate_r  <= out_rate_nxt;
    out_beat_r  <= out_beat_nxt;
    out_nosig_r <= out_nosig_nxt;
  end

  hrd_ring #(
    .AVG_WINDOW (AVG_WINDOW),
    .FILL_W     (FILL_W),
    .SUM_W      (SUM_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .wr_data (elapsed[INTERVAL_W-1:0]),
    .done    (ring_done),
    .sum     (ring_sum),
    .fill    (ring_fill)
  );

  hrd_divider #(
    .DVD_W (SUM_W),
    .DVS_W (INTERVAL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_nosig_r, out_beat_r, out_rate_r};

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EVAL)
    else $error("accepted transaction did not advance to evaluation");

  a_nosig_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tdata[15:0] == '0 && !out_tdata[16])
    else $error("no-signal result carries rate or beat");

  a_ring_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    ring_done |-> state_r == S_SUM)
    else $error("interval sum finished outside summing state");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV1 || state_r == S_DIV2)
    else $error("division finished outside division states");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start && state_r == S_SUM |-> ring_fill != '0)
    else $error("mean division started with empty history");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hrd_pkg::*;

  localparam int SAMPLE_MAX  = 2**SAMPLE_W - 1;
  localparam int IVL_MAX     = 2**INTERVAL_W - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 550;

  typedef struct {
    logic [RATE_W-1:0] rate;
    logic              beat;
    logic              nosig;
  } hr_result_t;

  class hr_scoreboard;
    logic [SAMPLE_W-1:0]   no_sig_lvl;
    logic [SAMPLE_W-1:0]   beat_lvl;
    logic [INTERVAL_W-1:0] min_ivl;
    logic [INTERVAL_W-1:0] max_ivl;
    logic [SAMPLE_W-1:0]   prev_ir;
    logic signed [SAMPLE_W:0] prev_slope;
    logic [TIME_W-1:0]     last_beat;
    logic [INTERVAL_W-1:0] intervals [AVG_WINDOW_DEF];
    int unsigned           wr_pos;
    int unsigned           fill;
    logic [RATE_W-1:0]     rate;
    hr_result_t            pending [$];
    int                    errors;
    int                    checked;
    int                    beats;
    int                    dropouts;

    function new();
      no_sig_lvl = NO_SIGNAL_RST;
      beat_lvl   = BEAT_RST;
      min_ivl    = MIN_IVL_RST;
      max_ivl    = MAX_IVL_RST;
      prev_ir    = '0;
      prev_slope = '0;
      last_beat  = '0;
      wr_pos     = 0;
      fill       = 0;
      rate       = '0;
      errors     = 0;
      checked    = 0;
      beats      = 0;
      dropouts   = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_NO_SIGNAL: no_sig_lvl = val;
        REG_BEAT:      beat_lvl = val;
        REG_MIN_IVL:   min_ivl = val[INTERVAL_W-1:0];
        REG_MAX_IVL:   max_ivl = val[INTERVAL_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] ir, logic [TIME_W-1:0] now);
      hr_result_t            r;
      logic signed [SAMPLE_W:0] slope;
      logic [TIME_W-1:0]     elapsed;
      int unsigned           sum;
      int unsigned           mean;
      r.beat  = 1'b0;
      r.nosig = 1'b0;
      if (ir < no_sig_lvl) begin
        r.nosig    = 1'b1;
        rate       = '0;
        last_beat  = now;
        wr_pos     = 0;
        fill       = 0;
        prev_ir    = ir;
        prev_slope = '0;
      end else begin
        slope   = $signed({1'b0, ir}) - $signed({1'b0, prev_ir});
        elapsed = now - last_beat;
        if (prev_slope > 0 && slope < 0 && prev_ir > beat_lvl && elapsed >= min_ivl) begin
          if (elapsed <= max_ivl) begin
            intervals[wr_pos] = elapsed[INTERVAL_W-1:0];
            wr_pos = (wr_pos + 1) % AVG_WINDOW_DEF;
            if (fill < AVG_WINDOW_DEF) fill++;
            sum = 0;
            for (int i = 0; i < fill; i++) sum += intervals[i];
            mean = sum / fill;
            rate = (mean > 0) ? RATE_W'(RATE_NUM / mean) : '0;
            r.beat = 1'b1;
          end
          last_beat = now;
        end
        prev_slope = slope;
        prev_ir    = ir;
      end
      r.rate = rate;
      pending.push_back(r);
    endfunction

    function void check_rate(logic [23:0] data);
      hr_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual tdata %h",
                 $time, data);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      beats    += data[16];
      dropouts += data[17];
      if (data[15:0] !== exp_r.rate) begin
        $display("%0t: rate_bpm mismatch, expected %0d, actual %0d",
                 $time, exp_r.rate, data[15:0]);
        errors++;
      end
      if (data[16] !== exp_r.beat) begin
        $display("%0t: beat_accepted mismatch, expected %0d, actual %0d",
                 $time, exp_r.beat, data[16]);
        errors++;
      end
      if (data[17] !== exp_r.nosig) begin
        $display("%0t: no_signal mismatch, expected %0d, actual %0d",
                 $time, exp_r.nosig, data[17]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [55:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  hr_scoreboard    sb = new();
  logic [TIME_W-1:0] clock_ms = '0;
  int              sent = 0;
  int              settings = 0;
  int              cycles = 0;
  bit              tx_calm = 1'b0;
  bit              rx_calm = 1'b0;
  int              stall_left = 0;
  int              calm_left = 0;

  ppg_heart_rate_detector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_rate(out_tdata);
  end

  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_gap();
    if (tx_calm) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return pick_len();
  endfunction

  // receiver backpressure, with calm stretches
  always @(negedge clk) begin
    if (calm_left == 0) begin
      rx_calm   = ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(100, 600);
    end else begin
      calm_left--;
    end
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      if (!rx_calm && $urandom_range(0, 5) == 0) stall_left = pick_len();
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] ir, logic [TIME_W-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'd0, now, ir};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(ir, now);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(int ns, int bt, int mn, int mx);
    wait_results();
    write_reg(REG_NO_SIGNAL, CFG_DATA_W'(ns));
    write_reg(REG_BEAT, CFG_DATA_W'(bt));
    write_reg(REG_MIN_IVL, CFG_DATA_W'(mn));
    write_reg(REG_MAX_IVL, CFG_DATA_W'(mx));
    settings++;
  endtask

  // one beat: rising ramp to a peak, then falling back down; steps go flat where the levels clamp at full scale
  task automatic pulse_beat();
    int lo;
    int hi;
    int period;
    int dt;
    int n;
    int rise;
    int fall;
    lo = int'(sb.no_sig_lvl) + $urandom_range(0, 3000);
    if (lo > SAMPLE_MAX) lo = SAMPLE_MAX;
    hi = (lo > int'(sb.beat_lvl) ? lo : int'(sb.beat_lvl)) + $urandom_range(2000, 60000);
    if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
    period = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 3000)
                                          : $urandom_range(350, 1800);
    dt = $urandom_range(40, 150);
    n = period / dt;
    if (n < 2) n = 2;
    rise = n / 2;
    fall = n - rise;
    for (int i = 1; i <= rise; i++) begin
      send_sample(SAMPLE_W'(lo + (hi - lo) * i / rise), clock_ms);
      clock_ms += dt;
    end
    for (int i = 1; i <= fall; i++) begin
      send_sample(SAMPLE_W'(hi - (hi - lo) * i / fall), clock_ms);
      clock_ms += dt;
    end
  endtask

  initial begin
    int phase;
    int phase_end;
    int pick;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // default registers: timestamp wrap, too long, too soon, threshold edges
    send_sample(18'd0, 32'hFFFF_FE00);
    send_sample(18'd60000, 32'hFFFF_FF00);
    send_sample(SAMPLE_W'(SAMPLE_MAX), 32'hFFFF_FF80);
    send_sample(18'd70000, 32'h0000_0010);
    send_sample(18'd80000, 32'd256);
    send_sample(18'd90000, 32'd336);
    send_sample(18'd85000, 32'd3000);
    send_sample(18'd95000, 32'd3100);
    send_sample(18'd96000, 32'd3200);
    send_sample(18'd50000, 32'd3300);
    send_sample(18'd29999, 32'd3400);
    send_sample(18'd30000, 32'hFFFF_FFFF);

    // maximum below minimum
    wait_results();
    write_reg(REG_MIN_IVL, 18'd1000);
    write_reg(REG_MAX_IVL, 18'd500);
    send_sample(18'd100000, 32'd4000);
    send_sample(18'd120000, 32'd5500);
    send_sample(18'd110000, 32'd6000);
    send_sample(18'd130000, 32'd6100);
    send_sample(18'd125000, 32'd7500);

    // zero minimum: zero interval enters the ring
    wait_results();
    write_reg(REG_MIN_IVL, 18'd0);
    write_reg(REG_MAX_IVL, CFG_DATA_W'(IVL_MAX));
    send_sample(18'd0, 32'd9000);
    send_sample(18'd100000, 32'd9000);
    send_sample(18'd150000, 32'd9000);
    send_sample(18'd120000, 32'd9000);

    phase = 0;
    phase_end = sent;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: apply_setting(NO_SIGNAL_RST, BEAT_RST, MIN_IVL_RST, MAX_IVL_RST);
        1: apply_setting(0, 0, 1, IVL_MAX);
        2: apply_setting(SAMPLE_MAX, SAMPLE_MAX, IVL_MAX, IVL_MAX);
        3: apply_setting(20000, 40000, 1200, 600);
        4: apply_setting(0, SAMPLE_MAX, 1, 1);
        default: begin
          if ($urandom_range(0, 3) == 0)
            apply_setting($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                          $urandom_range(1, IVL_MAX), $urandom_range(1, IVL_MAX));
          else
            apply_setting($urandom_range(1000, 60000), $urandom_range(40000, 120000),
                          $urandom_range(200, 700), $urandom_range(1200, 2500));
        end
      endcase
      tx_calm  = ($urandom_range(0, 3) == 0);
      clock_ms = (phase == 1) ? 32'hFFFF_F000 : $urandom();
      phase_end = sent + ((phase == 2) ? 20 : 60);
      while (sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          pulse_beat();
        end else if (pick == 7) begin
          send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), $urandom());
        end else if (pick == 8 && sb.no_sig_lvl > 0) begin
          send_sample(SAMPLE_W'($urandom_range(0, int'(sb.no_sig_lvl) - 1)), clock_ms);
          clock_ms += $urandom_range(10, 200);
        end else begin
          send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), clock_ms);
          clock_ms += $urandom_range(0, 300);
        end
      end
      phase++;
    end

    wait_results();
    repeat (60) @(negedge clk);
    $display("summary: %0d samples sent, %0d results checked, %0d beats, %0d dropouts",
             sent, sb.checked, sb.beats, sb.dropouts);
    $display("summary: %0d register settings incl. extremes, timestamp wrap, zero interval",
             settings);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
